/* hdl/bst_pkg.sv */
// ---------------------------------------------------------------------------
// bst_pkg
// Shared types, token kind codes and keyword table for the BASIC tokenizer.
// ---------------------------------------------------------------------------
package bst_pkg;

    localparam int KEYWORD_MAX_LEN_DEF = 8;
    localparam int POSITION_WIDTH_DEF  = 16;
    localparam int KIND_W  = 6;
    localparam int VAL_W   = 31;
    localparam int NUM_KEYWORDS = 23;
    localparam int KW_TEXT_LEN  = 8;

    localparam logic [KIND_W-1:0] K_EOL      = 6'd0;
    localparam logic [KIND_W-1:0] K_PLUS     = 6'd1;
    localparam logic [KIND_W-1:0] K_MINUS    = 6'd2;
    localparam logic [KIND_W-1:0] K_STAR     = 6'd3;
    localparam logic [KIND_W-1:0] K_SLASH    = 6'd4;
    localparam logic [KIND_W-1:0] K_COMMA    = 6'd5;
    localparam logic [KIND_W-1:0] K_LPAREN   = 6'd6;
    localparam logic [KIND_W-1:0] K_RPAREN   = 6'd7;
    localparam logic [KIND_W-1:0] K_LBRACK   = 6'd8;
    localparam logic [KIND_W-1:0] K_RBRACK   = 6'd9;
    localparam logic [KIND_W-1:0] K_LEQ      = 6'd10;
    localparam logic [KIND_W-1:0] K_LESS     = 6'd11;
    localparam logic [KIND_W-1:0] K_GEQ      = 6'd12;
    localparam logic [KIND_W-1:0] K_GREATER  = 6'd13;
    localparam logic [KIND_W-1:0] K_EQUAL    = 6'd14;
    localparam logic [KIND_W-1:0] K_PERCENT  = 6'd15;
    localparam logic [KIND_W-1:0] K_BANG     = 6'd16;
    localparam logic [KIND_W-1:0] K_DOLLAR   = 6'd17;
    localparam logic [KIND_W-1:0] K_COLON    = 6'd18;
    localparam logic [KIND_W-1:0] K_SEMI     = 6'd19;
    localparam logic [KIND_W-1:0] K_STRING   = 6'd20;
    localparam logic [KIND_W-1:0] K_HASH     = 6'd21;
    localparam logic [KIND_W-1:0] K_INTEGER  = 6'd22;
    localparam logic [KIND_W-1:0] K_FLOAT    = 6'd23;
    localparam logic [KIND_W-1:0] K_IDENT    = 6'd24;
    localparam logic [KIND_W-1:0] K_ILLEGAL  = 6'd25;
    localparam logic [KIND_W-1:0] K_EOF      = 6'd26;
    localparam logic [KIND_W-1:0] K_KEYWORD0 = 6'd27;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_COMMENT = 8'b0000_0010,
        M_LESS    = 8'b0000_0100,
        M_GREATER = 8'b0000_1000,
        M_STRING  = 8'b0001_0000,
        M_INT     = 8'b0010_0000,
        M_FRAC    = 8'b0100_0000,
        M_WORD    = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
        logic              ovf;
    } t_token;

    // keyword text, first character in the top byte, padded with zeros
    function automatic logic [8*KW_TEXT_LEN-1:0] kw_text(input int idx);
        logic [8*KW_TEXT_LEN-1:0] t;
        case (idx)
            0:  t = {"DIM", 40'd0};
            1:  t = {"IF", 48'd0};
            2:  t = {"THEN", 32'd0};
            3:  t = {"ELSE", 32'd0};
            4:  t = {"GOTO", 32'd0};
            5:  t = {"END", 40'd0};
            6:  t = {"RETURN", 16'd0};
            7:  t = {"WHILE", 24'd0};
            8:  t = {"WEND", 32'd0};
            9:  t = {"PRINT", 24'd0};
            10: t = {"DATA", 32'd0};
            11: t = {"READ", 32'd0};
            12: t = {"RESTORE", 8'd0};
            13: t = {"DECLARE", 8'd0};
            14: t = "FUNCTION";
            15: t = {"SUB", 40'd0};
            16: t = {"OPEN", 32'd0};
            17: t = {"FOR", 40'd0};
            18: t = {"BINARY", 16'd0};
            19: t = {"AS", 48'd0};
            20: t = {"GET", 40'd0};
            21: t = {"PUT", 40'd0};
            default: t = {"CLOSE", 24'd0};
        endcase
        return t;
    endfunction

    function automatic int kw_len(input int idx);
        int n;
        logic [8*KW_TEXT_LEN-1:0] t;
        t = kw_text(idx);
        n = 0;
        for (int i = 0; i < KW_TEXT_LEN; i++) begin
            if (t[8*(KW_TEXT_LEN-1-i) +: 8] != 8'd0) n = i + 1;
        end
        return n;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

endpackage

/* hdl/bst_if.sv */
// ---------------------------------------------------------------------------
// bst_in_if / bst_out_if
// Valid/ready channels for characters and tokens.
// ---------------------------------------------------------------------------
interface bst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;
    modport source (output valid, char_code, end_of_input, input ready);
    modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

interface bst_out_if #(parameter int POSITION_WIDTH = 16);
    logic                      valid;
    logic                      ready;
    logic [5:0]                token_kind;
    logic [POSITION_WIDTH-1:0] line_number;
    logic [POSITION_WIDTH-1:0] end_column;
    logic [30:0]               int_value;
    logic                      value_overflow;
    logic                      last_result;
    modport source (output valid, token_kind, line_number, end_column, int_value,
                    value_overflow, last_result, input ready);
    modport sink   (input valid, token_kind, line_number, end_column, int_value,
                    value_overflow, last_result, output ready);
endinterface

/* hdl/bst_kw_match.sv */
// ---------------------------------------------------------------------------
// bst_kw_match
// Compares the buffered word against the keyword table.
// ---------------------------------------------------------------------------
module bst_kw_match #(
    parameter int KEYWORD_MAX_LEN = bst_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int LEN_W = $clog2(KEYWORD_MAX_LEN + 2)
) (
    input  logic [KEYWORD_MAX_LEN-1:0][7:0] i_word,
    input  logic [LEN_W-1:0]                i_len,
    output logic [5:0]                      o_kind
);
    import bst_pkg::*;

    always_comb begin
        o_kind = K_IDENT;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            logic hit;
            logic [8*KW_TEXT_LEN-1:0] t;
            t   = kw_text(k);
            hit = (i_len == LEN_W'(kw_len(k))) && (kw_len(k) <= KEYWORD_MAX_LEN);
            for (int i = 0; i < KW_TEXT_LEN; i++) begin
                if (i < kw_len(k) && i < KEYWORD_MAX_LEN) begin
                    if (i_word[i] != t[8*(KW_TEXT_LEN-1-i) +: 8]) hit = 1'b0;
                end
            end
            if (hit) o_kind = K_KEYWORD0 + KIND_W'(k);
        end
    end
endmodule

/* hdl/bst_scan.sv */
// ---------------------------------------------------------------------------
// bst_scan
// Scanner state and per-character next-state and token logic.
// ---------------------------------------------------------------------------
module bst_scan #(
    parameter int KEYWORD_MAX_LEN = bst_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int POSITION_WIDTH  = bst_pkg::POSITION_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_char,
    input  logic                      i_eoi,
    // first token uses position before the terminating char advances
    output logic                      o_t0_vld,
    output bst_pkg::t_token           o_t0,
    output logic [POSITION_WIDTH-1:0] o_t0_line,
    output logic [POSITION_WIDTH-1:0] o_t0_col,
    output logic                      o_t1_vld,
    output bst_pkg::t_token           o_t1,
    output logic [POSITION_WIDTH-1:0] o_t1_line,
    output logic [POSITION_WIDTH-1:0] o_t1_col
);
    import bst_pkg::*;

    localparam int LEN_W = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    t_mode                           r_mode, n_mode;
    logic [POSITION_WIDTH-1:0]       r_line, n_line, r_col, n_col;
    logic [KEYWORD_MAX_LEN-1:0][7:0] r_word;
    logic [LEN_W-1:0]                r_len, n_len;
    logic [VAL_W-1:0]                r_acc, n_acc;
    logic                            r_ovf, n_ovf;
    logic                            wr_word;
    logic [IDX_W-1:0]                wr_idx;
    logic [5:0]                      word_kind;
    logic [34:0]                     acc_mul;

    bst_kw_match #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .LEN_W(LEN_W)) u_kw (
        .i_word (r_word),
        .i_len  (r_len),
        .o_kind (word_kind)
    );

    function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    assign acc_mul = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                   + {31'd0, i_char[3:0] - 4'd0};

    always_comb begin
        logic       pend;
        logic       do_idle;
        t_token     flush_tok;
        logic [7:0] c;
        c = i_char;
        n_mode = r_mode; n_line = r_line; n_col = r_col; n_len = r_len;
        n_acc = r_acc; n_ovf = r_ovf;
        wr_word = 1'b0; wr_idx = '0;
        o_t0_vld = 1'b0; o_t1_vld = 1'b0;
        o_t0 = '0; o_t1 = '0;
        o_t0_line = r_line; o_t0_col = r_col;
        o_t1_line = r_line; o_t1_col = r_col;
        do_idle = 1'b0;

        pend = 1'b1;
        flush_tok = '0;
        unique case (r_mode)
            M_LESS:    flush_tok.kind = K_LESS;
            M_GREATER: flush_tok.kind = K_GREATER;
            M_STRING:  flush_tok.kind = K_STRING;
            M_INT:     begin
                flush_tok.kind = K_INTEGER; flush_tok.value = r_acc; flush_tok.ovf = r_ovf;
            end
            M_FRAC:    flush_tok.kind = K_FLOAT;
            M_WORD:    flush_tok.kind = word_kind;
            default:   pend = 1'b0;
        endcase

        if (i_eoi) begin
            o_t0_vld = pend;
            o_t0 = flush_tok;
            n_mode = M_IDLE;
            n_col = sat_inc(r_col);
            o_t1_vld = 1'b1;
            o_t1.kind = K_EOF;
            o_t1_col = n_col;
        end else begin
            unique case (r_mode)
                M_COMMENT: begin
                    n_col = sat_inc(r_col);
                    if (c == 8'h0A) begin
                        n_mode = M_IDLE;
                        o_t1_vld = 1'b1; o_t1.kind = K_EOL; o_t1_col = n_col;
                        n_line = sat_inc(r_line); n_col = '0;
                    end
                end
                M_STRING: begin
                    n_col = sat_inc(r_col);
                    if (c == 8'h22) begin
                        n_mode = M_IDLE;
                        o_t1_vld = 1'b1; o_t1.kind = K_STRING; o_t1_col = n_col;
                    end
                end
                M_LESS, M_GREATER: begin
                    if (c == "=") begin
                        n_col = sat_inc(r_col);
                        n_mode = M_IDLE;
                        o_t1_vld = 1'b1;
                        o_t1.kind = (r_mode == M_LESS) ? K_LEQ : K_GEQ;
                        o_t1_col = n_col;
                    end else do_idle = 1'b1;
                end
                M_INT: begin
                    if (is_digit(c)) begin
                        n_col = sat_inc(r_col);
                        if (acc_mul > 35'(VAL_MAX)) begin
                            n_acc = VAL_MAX; n_ovf = 1'b1;
                        end else n_acc = acc_mul[VAL_W-1:0];
                    end else if (c == ".") begin
                        n_col = sat_inc(r_col);
                        n_mode = M_FRAC;
                    end else do_idle = 1'b1;
                end
                M_FRAC: begin
                    if (is_digit(c)) n_col = sat_inc(r_col);
                    else do_idle = 1'b1;
                end
                M_WORD: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        n_col = sat_inc(r_col);
                        if (r_len < LEN_W'(KEYWORD_MAX_LEN)) begin
                            wr_word = 1'b1; wr_idx = r_len[IDX_W-1:0];
                        end
                        if (r_len <= LEN_W'(KEYWORD_MAX_LEN)) n_len = r_len + 1'b1;
                    end else do_idle = 1'b1;
                end
                default: do_idle = 1'b1;
            endcase

            if (do_idle) begin
                o_t0_vld = pend;
                o_t0 = flush_tok;
                n_mode = M_IDLE;
                n_col = sat_inc(r_col);
                o_t1_col = n_col;
                o_t1_vld = 1'b1;
                case (c)
                    8'h20, 8'h09: o_t1_vld = 1'b0;
                    8'h27: begin o_t1_vld = 1'b0; n_mode = M_COMMENT; end
                    8'h0A: begin
                        o_t1.kind = K_EOL; n_line = sat_inc(r_line); n_col = '0;
                    end
                    "<": begin o_t1_vld = 1'b0; n_mode = M_LESS; end
                    ">": begin o_t1_vld = 1'b0; n_mode = M_GREATER; end
                    8'h22: begin o_t1_vld = 1'b0; n_mode = M_STRING; end
                    "+": o_t1.kind = K_PLUS;
                    "-": o_t1.kind = K_MINUS;
                    "*": o_t1.kind = K_STAR;
                    "/": o_t1.kind = K_SLASH;
                    ",": o_t1.kind = K_COMMA;
                    "(": o_t1.kind = K_LPAREN;
                    ")": o_t1.kind = K_RPAREN;
                    "[": o_t1.kind = K_LBRACK;
                    "]": o_t1.kind = K_RBRACK;
                    "=": o_t1.kind = K_EQUAL;
                    "%": o_t1.kind = K_PERCENT;
                    "!": o_t1.kind = K_BANG;
                    "$": o_t1.kind = K_DOLLAR;
                    ":": o_t1.kind = K_COLON;
                    ";": o_t1.kind = K_SEMI;
                    "#": o_t1.kind = K_HASH;
                    default: begin
                        if (is_digit(c)) begin
                            o_t1_vld = 1'b0; n_mode = M_INT;
                            n_acc = {27'd0, c[3:0]}; n_ovf = 1'b0;
                        end else if (is_alpha(c)) begin
                            o_t1_vld = 1'b0; n_mode = M_WORD;
                            wr_word = 1'b1; wr_idx = '0; n_len = LEN_W'(1);
                        end else o_t1.kind = K_ILLEGAL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= POSITION_WIDTH'(1);
            r_col  <= '0;
            r_len  <= '0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && wr_word) r_word[wr_idx] <= i_char;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(KEYWORD_MAX_LEN + 1))
        else $error("word length past limit");
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_acc == VAL_MAX) || (r_mode != M_INT))
        else $error("overflow without saturation");
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_eoi) |=> (r_mode == M_IDLE))
        else $error("mode not idle after end of input");
endmodule

/* hdl/basic_source_tokenizer.sv */
// ---------------------------------------------------------------------------
// basic_source_tokenizer
// Output: a token is registered and appears in the cycle after its character is taken.
// Rate: one character per cycle while the output slot is free; a character that yields two
// tokens holds input until the second token drains.
// Reset (synchronous, active low): idle, line 1, column 0, output empty.
// ---------------------------------------------------------------------------
module basic_source_tokenizer #(
    parameter int KEYWORD_MAX_LEN = bst_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int POSITION_WIDTH  = bst_pkg::POSITION_WIDTH_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    bst_in_if.sink  i_in,
    bst_out_if.source o_out
);
    import bst_pkg::*;

    logic                      step;
    logic                      t0_vld, t1_vld;
    t_token                    t0, t1;
    logic [POSITION_WIDTH-1:0] t0_line, t0_col, t1_line, t1_col;

    // output slot and one pending second token
    logic                      r_v0, r_v1;
    t_token                    r_k0, r_k1;
    logic [POSITION_WIDTH-1:0] r_l0, r_c0, r_l1, r_c1;
    logic                      r_last0, r_last1;
    logic                      out_take, slot_free;

    bst_scan #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .POSITION_WIDTH(POSITION_WIDTH)) u_scan (
        .i_clk, .i_rst_n, .i_step(step), .i_char(i_in.char_code), .i_eoi(i_in.end_of_input),
        .o_t0_vld(t0_vld), .o_t0(t0), .o_t0_line(t0_line), .o_t0_col(t0_col),
        .o_t1_vld(t1_vld), .o_t1(t1), .o_t1_line(t1_line), .o_t1_col(t1_col)
    );

    assign out_take  = r_v0 && o_out.ready;
    assign slot_free = !r_v1 && (!r_v0 || out_take);
    assign i_in.ready = slot_free;
    assign step = i_in.valid && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (step && (t0_vld || t1_vld)) begin
                r_v0 <= 1'b1;
                r_v1 <= t0_vld && t1_vld;
            end else if (out_take) begin
                r_v0 <= r_v1;
                r_v1 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (t0_vld || t1_vld)) begin
            if (t0_vld) begin
                r_k0 <= t0; r_l0 <= t0_line; r_c0 <= t0_col; r_last0 <= !t1_vld;
            end else begin
                r_k0 <= t1; r_l0 <= t1_line; r_c0 <= t1_col; r_last0 <= 1'b1;
            end
            r_k1 <= t1; r_l1 <= t1_line; r_c1 <= t1_col; r_last1 <= 1'b1;
        end else if (out_take) begin
            r_k0 <= r_k1; r_l0 <= r_l1; r_c0 <= r_c1; r_last0 <= r_last1;
        end
    end

    assign o_out.valid          = r_v0;
    assign o_out.token_kind     = r_k0.kind;
    assign o_out.line_number    = r_l0;
    assign o_out.end_column     = r_c0;
    assign o_out.int_value      = r_k0.value;
    assign o_out.value_overflow = r_k0.ovf;
    assign o_out.last_result    = r_last0;

    a_v1_needs_v0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second slot without first");
    a_no_take_when_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> !step)
        else $error("input taken with token pending");
    a_pend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> !r_last0)
        else $error("first of two tokens marked last");
endmodule
